### hdl/assert_macros.svh
// Concurrent assertion helpers, clocked on the rising edge and idle while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/cklm_pkg.sv
package cklm_pkg;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_SP  = 8'h20;

  localparam int unsigned NameRegWidth = 64;
  localparam int unsigned NameRegCount = 8;
  localparam int unsigned CfgIdxWidth  = 3;

  typedef enum logic [2:0] {
    ST_MATCH     = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_LONG      = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_EXHAUSTED = 3'd4
  } cklm_status_e;

  typedef enum logic [4:0] {
    PH_LEAD = 5'b00001,
    PH_WORD = 5'b00010,
    PH_GAP  = 5'b00100,
    PH_ARGS = 5'b01000,
    PH_DROP = 5'b10000
  } cklm_phase_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SINGLE = 5'b00100,
    S_READ   = 5'b01000,
    S_EMIT   = 5'b10000
  } cklm_state_e;

  typedef struct packed {
    logic [7:0] in_byte;
  } cklm_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] cmd_idx;
    logic [7:0] arg_byte;
    logic       arg_valid;
    logic       last;
  } cklm_out_t;

  // controller -> datapath
  typedef struct packed {
    logic take;
    logic set_early;
    logic search_start;
    logic search_step;
    logic rd;
    logic emit_next;
    logic out_single;
    logic out_arg;
    logic clear;
  } cklm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic line_end;
    logic skip_search;
    logic entry_zero;
    logic entry_match;
    logic entry_last;
    logic has_args;
    logic emit_last;
    logic out_free;
  } cklm_sts_t;

endpackage

### hdl/cklm_stream_if.sv
interface cklm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/cklm_ram.sv
module cklm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/cklm_ctrl.sv
module cklm_ctrl import cklm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cklm_sts_t sts_i,
  output cklm_cmd_t cmd_o
);

  cklm_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.line_end) begin
            if (sts_i.skip_search) begin
              cmd_o.set_early = 1'b1;
              state_d         = S_SINGLE;
            end else begin
              cmd_o.search_start = 1'b1;
              state_d            = S_SEARCH;
            end
          end
        end
      end
      S_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (sts_i.entry_zero || sts_i.entry_match || sts_i.entry_last) begin
          if (!sts_i.entry_zero && sts_i.entry_match && sts_i.has_args) begin
            state_d = S_READ;
          end else begin
            state_d = S_SINGLE;
          end
        end
      end
      S_SINGLE: begin
        if (sts_i.out_free) begin
          cmd_o.out_single = 1'b1;
          cmd_o.clear      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_arg = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d         = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/cklm_dp.sv
module cklm_dp import cklm_pkg::*; #(
  parameter int unsigned NAME_BUFFER   = 9,
  parameter int unsigned ARG_BUFFER    = 32,
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [NameRegWidth-1:0] cfg_data_i,
  input  logic [7:0]              in_byte_i,
  input  cklm_cmd_t               cmd_i,
  output cklm_sts_t               sts_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output cklm_out_t               out_data_o
);

  localparam int unsigned NLW = $clog2(NAME_BUFFER);
  localparam int unsigned NBW = 8 * (NAME_BUFFER - 1);
  localparam int unsigned ALW = $clog2(ARG_BUFFER);
  localparam int unsigned TIW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // keep the bytes in front of the first zero byte
  function automatic logic [NameRegWidth-1:0] cut_at_zero(input logic [NameRegWidth-1:0] v);
    logic [NameRegWidth-1:0] keep;
    logic                    alive;
    keep  = '0;
    alive = 1'b1;
    for (int i = 0; i < NameRegWidth / 8; i++) begin
      if (v[8*i +: 8] == CHAR_NUL) begin
        alive = 1'b0;
      end
      if (alive) begin
        keep[8*i +: 8] = v[8*i +: 8];
      end
    end
    return keep;
  endfunction

  logic [NameRegWidth-1:0] names_q [TABLE_ENTRIES];

  cklm_phase_e  phase_q, phase_d;
  logic [NBW-1:0] name_q, name_d;
  logic [NLW-1:0] name_len_q, name_len_d;
  logic [ALW-1:0] arg_len_q, arg_len_d;
  logic [ALW-1:0] trim_len_q, trim_len_d;
  logic           overlong_q, overlong_d;
  logic [TIW-1:0] entry_ptr_q, entry_ptr_d;
  logic [ALW-1:0] emit_ptr_q, emit_ptr_d;
  cklm_status_e   status_q, status_d;
  logic [TIW-1:0] idx_q, idx_d;
  logic           out_valid_q;
  cklm_out_t      out_q;

  logic                    blank;
  logic                    store;
  logic                    ram_we;
  logic [7:0]              ram_rdata;
  logic [NameRegWidth-1:0] entry;
  logic                    out_free;
  logic                    emit_last;

  assign blank     = (in_byte_i == CHAR_SP) || (in_byte_i == CHAR_TAB);
  assign entry     = names_q[entry_ptr_q];
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_last = ({1'b0, emit_ptr_q} + 1'b1) == {1'b0, trim_len_q};

  assign sts_o.line_end    = (in_byte_i == CHAR_NUL) || (in_byte_i == CHAR_CR) ||
                             (in_byte_i == CHAR_LF);
  assign sts_o.skip_search = overlong_q || (phase_q == PH_LEAD);
  assign sts_o.entry_zero  = (entry == '0);
  assign sts_o.entry_match = (cut_at_zero(entry) == NameRegWidth'(name_q));
  assign sts_o.entry_last  = (entry_ptr_q == TIW'(TABLE_ENTRIES - 1));
  assign sts_o.has_args    = (trim_len_q != '0);
  assign sts_o.emit_last   = emit_last;
  assign sts_o.out_free    = out_free;

  // line parser
  always_comb begin
    phase_d    = phase_q;
    name_d     = name_q;
    name_len_d = name_len_q;
    arg_len_d  = arg_len_q;
    trim_len_d = trim_len_q;
    overlong_d = overlong_q;
    store      = 1'b0;
    ram_we     = 1'b0;
    if (cmd_i.clear) begin
      phase_d    = PH_LEAD;
      name_d     = '0;
      name_len_d = '0;
      arg_len_d  = '0;
      trim_len_d = '0;
      overlong_d = 1'b0;
    end else if (cmd_i.take && !sts_o.line_end) begin
      unique case (phase_q)
        PH_LEAD, PH_WORD: begin
          if (blank) begin
            if (phase_q == PH_WORD) begin
              phase_d = PH_GAP;
            end
          end else if (name_len_q == NLW'(NAME_BUFFER - 1)) begin
            overlong_d = 1'b1;
            phase_d    = PH_DROP;
          end else begin
            for (int k = 0; k < NAME_BUFFER - 1; k++) begin
              if (name_len_q == NLW'(k)) begin
                name_d[8*k +: 8] = in_byte_i;
              end
            end
            name_len_d = name_len_q + 1'b1;
            phase_d    = PH_WORD;
          end
        end
        PH_GAP: begin
          store = !blank;
        end
        PH_ARGS: begin
          store = 1'b1;
        end
        default: begin
        end
      endcase
      if (store) begin
        if (arg_len_q == ALW'(ARG_BUFFER - 1)) begin
          overlong_d = 1'b1;
          phase_d    = PH_DROP;
        end else begin
          ram_we    = 1'b1;
          arg_len_d = arg_len_q + 1'b1;
          phase_d   = PH_ARGS;
          // trailing blanks never move the trimmed end
          if (!blank) begin
            trim_len_d = arg_len_q + 1'b1;
          end
        end
      end
    end
  end

  // table search and emission pointers
  always_comb begin
    entry_ptr_d = entry_ptr_q;
    emit_ptr_d  = emit_ptr_q;
    status_d    = status_q;
    idx_d       = idx_q;
    if (cmd_i.set_early) begin
      status_d = overlong_q ? ST_LONG : ST_EMPTY;
      idx_d    = '0;
    end
    if (cmd_i.search_start) begin
      entry_ptr_d = '0;
      idx_d       = '0;
    end
    if (cmd_i.search_step) begin
      priority if (sts_o.entry_zero) begin
        status_d = ST_NOTFOUND;
      end else if (sts_o.entry_match) begin
        status_d = ST_MATCH;
        idx_d    = entry_ptr_q;
      end else if (sts_o.entry_last) begin
        status_d = ST_EXHAUSTED;
      end else begin
        entry_ptr_d = entry_ptr_q + 1'b1;
      end
    end
    if (cmd_i.emit_next) begin
      emit_ptr_d = emit_ptr_q + 1'b1;
    end
    if (cmd_i.clear) begin
      emit_ptr_d = '0;
    end
  end

  cklm_ram #(
    .WIDTH (8),
    .DEPTH (ARG_BUFFER)
  ) u_arg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (arg_len_q),
    .wdata_i (in_byte_i),
    .re_i    (cmd_i.rd),
    .raddr_i (emit_ptr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        names_q[i] <= '0;
      end
      phase_q     <= PH_LEAD;
      name_q      <= '0;
      name_len_q  <= '0;
      arg_len_q   <= '0;
      trim_len_q  <= '0;
      overlong_q  <= 1'b0;
      entry_ptr_q <= '0;
      emit_ptr_q  <= '0;
      status_q    <= ST_EMPTY;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (cfg_we_i && (cfg_idx_i == CfgIdxWidth'(i))) begin
          names_q[i] <= cfg_data_i;
        end
      end
      phase_q     <= phase_d;
      name_q      <= name_d;
      name_len_q  <= name_len_d;
      arg_len_q   <= arg_len_d;
      trim_len_q  <= trim_len_d;
      overlong_q  <= overlong_d;
      entry_ptr_q <= entry_ptr_d;
      emit_ptr_q  <= emit_ptr_d;
      status_q    <= status_d;
      idx_q       <= idx_d;
      if (cmd_i.out_single || cmd_i.out_arg) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_single) begin
      out_q.status    <= status_q;
      out_q.cmd_idx   <= 3'(idx_q);
      out_q.arg_byte  <= '0;
      out_q.arg_valid <= 1'b0;
      out_q.last      <= 1'b1;
    end else if (cmd_i.out_arg) begin
      out_q.status    <= status_q;
      out_q.cmd_idx   <= 3'(idx_q);
      out_q.arg_byte  <= ram_rdata;
      out_q.arg_valid <= 1'b1;
      out_q.last      <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/command_line_keyword_matcher.sv
// A character that does not end the line is taken while the sequencer is idle.
// A line end is taken, then the name table is searched entry by entry (not for a blank
// or overlong line), then a lone word is loaded, or each argument word is read, then loaded.
// Throughput: one character per cycle while parsing; each word load waits for the sink.
// Reset: async active low; clears the parser, the name table and the output valid.
// The argument RAM is not cleared; only entries written on the current line are read.
`include "assert_macros.svh"

module command_line_keyword_matcher import cklm_pkg::*; #(
  parameter int unsigned NAME_BUFFER   = 9,
  parameter int unsigned ARG_BUFFER    = 32,
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [NameRegWidth-1:0] cfg_data_i,
  cklm_stream_if.sink             in_i,
  cklm_stream_if.source           out_o
);

  // Command and status bundles between the sequencer and the datapath.
  cklm_cmd_t cmd;
  cklm_sts_t sts;

  // Sequencer: takes characters while idle, then walks the name table and
  // the buffered argument once a line end arrives.
  cklm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: parser registers, name table, argument RAM and the output
  // word register. The output register lets the sequencer move on to the
  // next line while the last word still waits for the sink.
  cklm_dp #(
    .NAME_BUFFER   (NAME_BUFFER),
    .ARG_BUFFER    (ARG_BUFFER),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_byte_i   (in_i.data.in_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

  // Never load the output register over a word the sink has not taken.
  `ASSERT_IMPLIES(a_load_when_free, clk_i, rst_ni, cmd.out_single || cmd.out_arg, sts.out_free)
  // Once the table search starts, hold off new characters.
  `ASSERT_NEXT(a_busy_after_search, clk_i, rst_ni, cmd.search_start, !in_i.ready)
  // A word without an argument character always closes the line.
  `ASSERT_IMPLIES(a_single_is_last, clk_i, rst_ni, out_o.valid && !out_o.data.arg_valid, out_o.data.last)
  // Argument characters only follow a match.
  `ASSERT_IMPLIES(a_arg_needs_match, clk_i, rst_ni, out_o.valid && out_o.data.arg_valid, out_o.data.status == ST_MATCH)

endmodule
